FILE: src/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int OPERAND_BITS = 31;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS);
   localparam int PC_BITS      = 4;

   typedef struct packed {
      logic [OPERAND_BITS-1:0] base;
      logic [OPERAND_BITS-1:0] exponent;
      logic [OPERAND_BITS-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [OPERAND_BITS-1:0] power_residue;
      logic                    bad_modulus;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,
      OP_LDX,
      OP_MUL,
      OP_SETX,
      OP_LDSQ,
      OP_STSQ,
      OP_LDMX,
      OP_STMX,
      OP_SHIFT,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_WORD,
      COND_BAD,
      COND_MUL_MORE,
      COND_EBIT_CLR,
      COND_EXP_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      logic [PC_BITS-1:0] target;
   } ucode_type;

   localparam logic [PC_BITS-1:0] PC_WAIT = 4'd0;
   localparam logic [PC_BITS-1:0] PC_LDX  = 4'd1;
   localparam logic [PC_BITS-1:0] PC_MULX = 4'd2;
   localparam logic [PC_BITS-1:0] PC_SETX = 4'd3;
   localparam logic [PC_BITS-1:0] PC_LDSQ = 4'd4;
   localparam logic [PC_BITS-1:0] PC_MULS = 4'd5;
   localparam logic [PC_BITS-1:0] PC_STSQ = 4'd6;
   localparam logic [PC_BITS-1:0] PC_LDMX = 4'd7;
   localparam logic [PC_BITS-1:0] PC_MULM = 4'd8;
   localparam logic [PC_BITS-1:0] PC_STMX = 4'd9;
   localparam logic [PC_BITS-1:0] PC_SHFT = 4'd10;
   localparam logic [PC_BITS-1:0] PC_DONE = 4'd11;
   localparam logic [PC_BITS-1:0] PC_BACK = 4'd12;

   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      unique case (pc)
         PC_WAIT: w = '{OP_WAIT,  COND_NO_WORD,  PC_WAIT};
         PC_LDX:  w = '{OP_LDX,   COND_BAD,      PC_DONE};
         PC_MULX: w = '{OP_MUL,   COND_MUL_MORE, PC_MULX};
         PC_SETX: w = '{OP_SETX,  COND_NEVER,    PC_WAIT};
         PC_LDSQ: w = '{OP_LDSQ,  COND_NEVER,    PC_WAIT};
         PC_MULS: w = '{OP_MUL,   COND_MUL_MORE, PC_MULS};
         PC_STSQ: w = '{OP_STSQ,  COND_EBIT_CLR, PC_SHFT};
         PC_LDMX: w = '{OP_LDMX,  COND_NEVER,    PC_WAIT};
         PC_MULM: w = '{OP_MUL,   COND_MUL_MORE, PC_MULM};
         PC_STMX: w = '{OP_STMX,  COND_NEVER,    PC_WAIT};
         PC_SHFT: w = '{OP_SHIFT, COND_EXP_MORE, PC_LDSQ};
         PC_DONE: w = '{OP_DONE,  COND_OUT_BUSY, PC_DONE};
         PC_BACK: w = '{OP_NOP,   COND_ALWAYS,   PC_WAIT};
         default: w = '{OP_NOP,   COND_ALWAYS,   PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

FILE: src/modular_exponentiation.sv
// a zero modulus goes straight to the done step; otherwise the base is reduced first,
// then each exponent bit takes a modular squaring plus a multiply when the bit is set
// throughput: one word at a time, the next one accepted only after the result
// is presented; the shift-and-add modular multiplier takes one bit per cycle
// reset: synchronous, active high; clears the program counter and the result valid
`timescale 1ns / 1ps

module modular_exponentiation (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  modexp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output modexp_pkg::rsp_type rsp_data
);

   localparam int N = modexp_pkg::OPERAND_BITS;
   localparam logic [modexp_pkg::CNT_BITS-1:0] CNT_LAST = modexp_pkg::CNT_BITS'(N - 1);

   logic [modexp_pkg::PC_BITS-1:0]  pc_ff, pc_in;
   logic [N-1:0]                    x_ff, y_ff, m_ff, xr_ff, acc_ff;
   logic [N-1:0]                    a_ff, b_ff, prod_ff;
   logic [modexp_pkg::CNT_BITS-1:0] cnt_ff, ecnt_ff;
   logic                            bad_ff;
   logic                            rsp_valid_ff;
   modexp_pkg::rsp_type             rsp_data_ff;

   modexp_pkg::ucode_type           uw;
   logic                            accept;
   logic                            jump;
   logic [N-1:0]                    one_mod;
   logic [N:0]                      dbl_sum, add_sum;
   logic [N-1:0]                    dbl_red, mul_next;

   assign uw        = modexp_pkg::ucode_rom(pc_ff);
   assign req_ready = (uw.op == modexp_pkg::OP_WAIT);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign one_mod = (m_ff == N'(1)) ? '0 : N'(1);

   // one shift-and-add step: double, then add a when the multiplier bit is set
   always_comb begin
      dbl_sum  = {prod_ff, 1'b0};
      dbl_red  = (dbl_sum >= {1'b0, m_ff}) ? N'(dbl_sum - {1'b0, m_ff}) : N'(dbl_sum);
      add_sum  = {1'b0, dbl_red} + {1'b0, a_ff};
      if (b_ff[N-1]) begin
         mul_next = (add_sum >= {1'b0, m_ff}) ? N'(add_sum - {1'b0, m_ff}) : N'(add_sum);
      end else begin
         mul_next = dbl_red;
      end
   end

   always_comb begin
      unique case (uw.cond)
         modexp_pkg::COND_NEVER:    jump = 1'b0;
         modexp_pkg::COND_ALWAYS:   jump = 1'b1;
         modexp_pkg::COND_NO_WORD:  jump = !accept;
         modexp_pkg::COND_BAD:      jump = bad_ff;
         modexp_pkg::COND_MUL_MORE: jump = (cnt_ff != '0);
         modexp_pkg::COND_EBIT_CLR: jump = !y_ff[N-1];
         modexp_pkg::COND_EXP_MORE: jump = (ecnt_ff != '0);
         modexp_pkg::COND_OUT_BUSY: jump = rsp_valid_ff && !rsp_ready;
         default:                   jump = 1'b1;
      endcase
      pc_in = jump ? uw.target : modexp_pkg::PC_BITS'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= modexp_pkg::PC_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (uw.op == modexp_pkg::OP_DONE && !(rsp_valid_ff && !rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (uw.op)
         modexp_pkg::OP_WAIT: begin
            if (accept) begin
               x_ff   <= req_data.base;
               y_ff   <= req_data.exponent;
               m_ff   <= req_data.modulus;
               bad_ff <= (req_data.modulus == '0);
            end
         end
         modexp_pkg::OP_LDX: begin
            a_ff    <= one_mod;
            b_ff    <= x_ff;
            prod_ff <= '0;
            cnt_ff  <= CNT_LAST;
         end
         modexp_pkg::OP_MUL: begin
            prod_ff <= mul_next;
            b_ff    <= {b_ff[N-2:0], 1'b0};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         modexp_pkg::OP_SETX: begin
            xr_ff   <= prod_ff;
            acc_ff  <= one_mod;
            ecnt_ff <= CNT_LAST;
         end
         modexp_pkg::OP_LDSQ: begin
            a_ff    <= acc_ff;
            b_ff    <= acc_ff;
            prod_ff <= '0;
            cnt_ff  <= CNT_LAST;
         end
         modexp_pkg::OP_LDMX: begin
            a_ff    <= xr_ff;
            b_ff    <= acc_ff;
            prod_ff <= '0;
            cnt_ff  <= CNT_LAST;
         end
         modexp_pkg::OP_STSQ,
         modexp_pkg::OP_STMX: begin
            acc_ff <= prod_ff;
         end
         modexp_pkg::OP_SHIFT: begin
            y_ff    <= {y_ff[N-2:0], 1'b0};
            ecnt_ff <= ecnt_ff - 1'b1;
         end
         modexp_pkg::OP_DONE: begin
            if (!(rsp_valid_ff && !rsp_ready)) begin
               rsp_data_ff.power_residue <= bad_ff ? '0 : acc_ff;
               rsp_data_ff.bad_modulus   <= bad_ff;
            end
         end
         modexp_pkg::OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   // zero modulus always reports a zero residue
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_modulus) |-> (rsp_data.power_residue == '0))
      else $error("flagged word with nonzero residue");

   // an accepted word starts the program
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pc_ff == modexp_pkg::PC_LDX))
      else $error("program did not start after accept");

   // partial product stays reduced while multiplying
   a_prod_red: assert property (@(posedge clock) disable iff (reset)
      (uw.op == modexp_pkg::OP_MUL) |-> (prod_ff < m_ff))
      else $error("partial product not reduced");

   // running power stays reduced at each exponent step
   a_acc_red: assert property (@(posedge clock) disable iff (reset)
      (uw.op == modexp_pkg::OP_SHIFT) |-> (acc_ff < m_ff))
      else $error("running power not reduced");

   // a new result only comes from the done step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(uw.op == modexp_pkg::OP_DONE))
      else $error("result valid without done step");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int OPERAND_BITS = modexp_pkg::OPERAND_BITS;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int DRAIN_CYCLES = 2200;
   localparam int LONG_HOLD    = 3000;
   localparam logic [OPERAND_BITS-1:0] ALL_ONES = '1;
   localparam logic [OPERAND_BITS-1:0] TOP_BIT  = OPERAND_BITS'(1) << (OPERAND_BITS - 1);

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   modexp_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   modexp_pkg::rsp_type rsp_data;

   modexp_pkg::rsp_type expected_results[$];
   modexp_pkg::rsp_type want;
   int      error_count = 0;
   int      cycle_count = 0;
   int      stall_request = 0;
   bit      no_idle = 1'b0;

   modular_exponentiation i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic modexp_pkg::rsp_type modpow_expected(input modexp_pkg::req_type w);
      logic [63:0] b;
      logic [63:0] e;
      logic [63:0] m;
      logic [63:0] acc;
      modexp_pkg::rsp_type r;
      r = '0;
      if (w.modulus == '0) begin
         r.bad_modulus = 1'b1;
         return r;
      end
      m = 64'(w.modulus);
      b = 64'(w.base) % m;
      e = 64'(w.exponent);
      acc = 64'd1 % m;
      while (e != 0) begin
         if (e[0]) begin
            acc = (acc * b) % m;
         end
         b = (b * b) % m;
         e = e >> 1;
      end
      r.power_residue = acc[OPERAND_BITS-1:0];
      return r;
   endfunction

   function automatic modexp_pkg::req_type make_word(input logic [OPERAND_BITS-1:0] b,
                                                     input logic [OPERAND_BITS-1:0] e,
                                                     input logic [OPERAND_BITS-1:0] m);
      modexp_pkg::req_type w;
      w.base     = b;
      w.exponent = e;
      w.modulus  = m;
      return w;
   endfunction

   function automatic logic [OPERAND_BITS-1:0] pick_operand();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      unique case ($urandom_range(0, 7))
         0: return OPERAND_BITS'($urandom_range(0, 15));
         1: return ALL_ONES;
         2: return ALL_ONES - OPERAND_BITS'($urandom_range(1, 8));
         default: return r[OPERAND_BITS-1:0];
      endcase
   endfunction

   function automatic logic [OPERAND_BITS-1:0] pick_modulus();
      unique case ($urandom_range(0, 19))
         0: return '0;
         1, 2: return OPERAND_BITS'($urandom_range(1, 16));
         default: return pick_operand();
      endcase
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // holds valid high across back-to-back words; lowers it only for a gap
   task automatic send_word(input modexp_pkg::req_type w);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(modpow_expected(w));
   endtask

   task automatic send_random_words(input int count);
      for (int i = 0; i < count; i++) begin
         send_word(make_word(pick_operand(), pick_operand(), pick_modulus()));
      end
   endtask

   task automatic test_corner_cases();
      send_word(make_word('0, '0, OPERAND_BITS'(1)));
      send_word(make_word(OPERAND_BITS'(5), '0, OPERAND_BITS'(7)));
      send_word(make_word('0, OPERAND_BITS'(5), OPERAND_BITS'(13)));
      send_word(make_word('0, '0, '0));
      send_word(make_word(ALL_ONES, ALL_ONES, '0));
      send_word(make_word(ALL_ONES, ALL_ONES, ALL_ONES));
      send_word(make_word(ALL_ONES, OPERAND_BITS'(1), ALL_ONES));
      send_word(make_word(ALL_ONES - OPERAND_BITS'(1), ALL_ONES, ALL_ONES));
      send_word(make_word(OPERAND_BITS'(2), OPERAND_BITS'(OPERAND_BITS - 1), ALL_ONES));
      send_word(make_word(OPERAND_BITS'(2), OPERAND_BITS'(OPERAND_BITS), ALL_ONES));
      send_word(make_word(OPERAND_BITS'(3), ALL_ONES, OPERAND_BITS'(2)));
      send_word(make_word(ALL_ONES, OPERAND_BITS'(2), OPERAND_BITS'(1000003)));
      send_word(make_word(OPERAND_BITS'(12345), OPERAND_BITS'(1), ALL_ONES - OPERAND_BITS'(4)));
      send_word(make_word(OPERAND_BITS'(7), ALL_ONES, OPERAND_BITS'(1)));
      send_word(make_word(TOP_BIT, OPERAND_BITS'(2), TOP_BIT + OPERAND_BITS'(1)));
      send_word(make_word(31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFB));
      send_word(make_word(31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555));
      send_word(make_word(OPERAND_BITS'(1), ALL_ONES, OPERAND_BITS'(3)));
      send_word(make_word(ALL_ONES, '0, ALL_ONES));
      send_word(make_word('0, ALL_ONES, ALL_ONES));
   endtask

   task automatic test_random_operands();
      send_random_words(85);
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_output_stall();
      stall_request = LONG_HOLD;
      send_word(make_word(pick_operand(), pick_operand(), '0));
      send_word(make_word(pick_operand(), pick_operand(), '0));
      send_word(make_word(pick_operand(), pick_operand(), pick_modulus()));
      send_word(make_word(pick_operand(), pick_operand(), '0));
      send_word(make_word(pick_operand(), pick_operand(), pick_modulus()));
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      send_random_words(30);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_random_operands();
      test_output_stall();
      test_back_to_back();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_request) @(posedge clock);
            stall_request = 0;
            rsp_ready <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            flag_error($sformatf("unexpected word: residue %0d bad %0b",
                                 rsp_data.power_residue, rsp_data.bad_modulus));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.power_residue !== want.power_residue) begin
               flag_error($sformatf("power_residue mismatch: expected %0d, got %0d",
                                    want.power_residue, rsp_data.power_residue));
            end
            if (rsp_data.bad_modulus !== want.bad_modulus) begin
               flag_error($sformatf("bad_modulus mismatch: expected %0b, got %0b",
                                    want.bad_modulus, rsp_data.bad_modulus));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule

FILE: files.f
src/modexp_pkg.sv
src/modular_exponentiation.sv
tb/testbench.sv
